// ===== rtl/core/angle_median_ema_filter_assert.svh =====
// Assertion macros for the angle median/EMA filter core.
// Included by the top level; expects clk and rst_n at the point of use.
`ifndef ANGLE_MEDIAN_EMA_FILTER_ASSERT_SVH
`define ANGLE_MEDIAN_EMA_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AMF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define AMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AMF_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define AMF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/amf_pkg.sv =====
// Shared types and constants of the angle median/EMA filter core.
// No dependencies; used by the sort cell, the sort chain and the top level.
`timescale 1ns / 1ps
package amf_pkg;

  localparam int RAW_W      = 16;
  localparam int ANGLE_W    = 14;
  localparam int ALPHA_W    = 9;
  localparam int CONF_W     = 8;
  localparam int FRAC_W     = 8;
  localparam int SMOOTH_W   = ANGLE_W + FRAC_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 14'd11520;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = 9'd256;

  localparam logic [ALPHA_W-1:0] ALPHA_RST     = 9'd77;
  localparam logic [ANGLE_W-1:0] THRESHOLD_RST = 14'd32;
  localparam logic [CONF_W-1:0]  CONFIRM_RST   = 8'd3;

  localparam logic [CFG_IDX_W-1:0] REG_EMA_ALPHA      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_CONFIRM   = 2'd2;

  // What one sort cell shows its right-hand neighbor.
  typedef struct packed {
    logic [ANGLE_W-1:0] val;
    logic               valid;
    logic               gt;
  } sort_link_t;

endpackage

// ===== rtl/core/angle_median_ema_filter.sv =====
// Top level of the angle median/EMA filter core.
// Depends on amf_pkg, amf_sort_chain and angle_median_ema_filter_assert.svh.
`timescale 1ns / 1ps
// Smooths one arrival angle per frame, in 1/64 degree. Each input transfer
// produces exactly one output transfer. The angle is clamped to 0..180
// degrees; an angle at or below zero_threshold is held back (the last output
// is repeated with updated low) until zero_confirm_frames such frames have
// come in a row. An accepted angle goes into a ring of WINDOW entries, the
// filled entries are streamed through a row of sort cells one per cycle, and
// the median (truncated mean of the two middle values for an even count)
// drives an exponential average with weight ema_alpha/256; the first accepted
// median loads the average. A rejected frame goes straight to the emit step and
// loads its result into the output register once that register is free. An
// accepted frame steps through scan, drain, median, multiply, update and emit,
// the scan feeding the sort cells one ring entry per cycle through the single
// ring read port; the very first accepted frame loads the average without the
// multiply and skips the update step. The next frame is taken in the cycle
// after the result is loaded. The result sits in an output register, so a new
// frame can be taken while it waits. Configuration writes are always ready
// and are meant to arrive only while the block is idle.
module angle_median_ema_filter #(
  parameter int WINDOW = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input: raw_angle [15:0], signed.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,
  // Output tdata: filtered_angle [13:0], zero padding [15:14].
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,
  // Output tuser: updated [0], has_value [1].
  output logic [1:0]                     out_tuser,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [amf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [amf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import amf_pkg::*;
  `include "angle_median_ema_filter_assert.svh"

  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int DIFF_W = SMOOTH_W + 1;
  localparam int PROD_W = ALPHA_W + 1 + DIFF_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MEDIAN,
    ST_MULT,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [ALPHA_W-1:0] alpha_r;
  logic [ANGLE_W-1:0] thr_r;
  logic [CONF_W-1:0]  conf_r;

  // Filter state.
  logic [ANGLE_W-1:0]  ring_mem [WINDOW];
  logic [IDX_W-1:0]    wpos_r;
  logic [CNT_W-1:0]    fill_r;
  logic [CONF_W-1:0]   zrun_r;
  logic [SMOOTH_W-1:0] smooth_r;
  logic                primed_r;

  // Working registers.
  logic [IDX_W-1:0]         rd_idx_r;
  logic [ANGLE_W-1:0]       rd_data_r;
  logic                     feed_en_r;
  logic [ANGLE_W-1:0]       med_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     upd_r;

  // Output registers.
  logic                out_valid_r;
  logic [ANGLE_W-1:0]  out_angle_r;
  logic                out_upd_r;
  logic                out_has_r;

  logic in_fire;
  logic out_free;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16 - ANGLE_W){1'b0}}, out_angle_r};
  assign out_tuser  = {out_has_r, out_upd_r};

  // Clamp and the zero-run decision, evaluated on the incoming transfer.
  logic [ANGLE_W-1:0] angle_c;
  logic               is_zero;
  logic [CONF_W-1:0]  zrun_inc;
  logic               reject;

  always_comb begin
    if (in_tdata[RAW_W-1]) begin
      angle_c = '0;
    end else if (in_tdata[RAW_W-2:0] > {1'b0, ANGLE_MAX}) begin
      angle_c = ANGLE_MAX;
    end else begin
      angle_c = in_tdata[ANGLE_W-1:0];
    end
  end

  assign is_zero  = (angle_c <= thr_r);
  assign zrun_inc = (zrun_r < conf_r) ? zrun_r + CONF_W'(1) : zrun_r;
  assign reject   = is_zero && (zrun_inc < conf_r);

  // Ring bookkeeping.
  logic [IDX_W-1:0] wpos_nxt;
  logic [CNT_W-1:0] fill_nxt;
  logic             scan_last;

  assign wpos_nxt  = (wpos_r == IDX_W'(WINDOW - 1)) ? '0 : wpos_r + IDX_W'(1);
  assign fill_nxt  = (fill_r < CNT_W'(WINDOW)) ? fill_r + CNT_W'(1) : fill_r;
  assign scan_last = ((CNT_W'(rd_idx_r) + CNT_W'(1)) == fill_r);

  always_ff @(posedge clk) begin
    if (in_fire && !reject) begin
      ring_mem[wpos_r] <= angle_c;
    end
    rd_data_r <= ring_mem[rd_idx_r];
  end

  // Sorter and median selection.
  logic [IDX_W-1:0]   half_idx;
  logic               even_cnt;
  logic [ANGLE_W-1:0] mid_hi;
  logic [ANGLE_W-1:0] mid_lo;
  logic [ANGLE_W:0]   mid_sum;
  logic [ANGLE_W-1:0] med_c;

  assign half_idx = IDX_W'(fill_r >> 1);
  assign even_cnt = !fill_r[0];

  amf_sort_chain #(
    .WINDOW (WINDOW),
    .IDX_W  (IDX_W)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (in_fire),
    .feed_en  (feed_en_r),
    .feed_val (rd_data_r),
    .half_idx (half_idx),
    .mid_hi   (mid_hi),
    .mid_lo   (mid_lo)
  );

  assign mid_sum = {1'b0, mid_lo} + {1'b0, mid_hi};
  assign med_c   = even_cnt ? mid_sum[ANGLE_W:1] : mid_hi;

  // Exponential average arithmetic.
  logic [ALPHA_W-1:0]       alpha_sat;
  logic signed [ALPHA_W:0]  alpha_s;
  logic signed [DIFF_W-1:0] diff_c;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [PROD_W-1:0] acc_c;
  logic [SMOOTH_W:0]        round_c;
  logic [ANGLE_W-1:0]       held_c;

  assign alpha_sat = (alpha_r > ALPHA_MAX) ? ALPHA_MAX : alpha_r;
  assign alpha_s   = signed'({1'b0, alpha_sat});
  assign diff_c    = signed'({1'b0, med_r, {FRAC_W{1'b0}}}) - signed'({1'b0, smooth_r});
  assign prod_c    = alpha_s * diff_c;
  // An arithmetic shift of the product is the floor of the division by 256.
  assign acc_c     = signed'(PROD_W'({1'b0, smooth_r})) + (prod_r >>> FRAC_W);
  assign round_c   = {1'b0, smooth_r} + (SMOOTH_W + 1)'(1 << (FRAC_W - 1));
  assign held_c    = primed_r ? round_c[SMOOTH_W-1:FRAC_W] : '0;

  // Configuration writes; indexes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RST;
      thr_r   <= THRESHOLD_RST;
      conf_r  <= CONFIRM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EMA_ALPHA:      alpha_r <= cfg_data[ALPHA_W-1:0];
        REG_ZERO_THRESHOLD: thr_r   <= cfg_data[ANGLE_W-1:0];
        REG_ZERO_CONFIRM:   conf_r  <= cfg_data[CONF_W-1:0];
        default:            ;
      endcase
    end
  end

  // Sequencer: state, filter state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wpos_r      <= '0;
      fill_r      <= '0;
      zrun_r      <= '0;
      smooth_r    <= '0;
      primed_r    <= 1'b0;
      rd_idx_r    <= '0;
      feed_en_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      feed_en_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            zrun_r   <= is_zero ? zrun_inc : '0;
            upd_r    <= !reject;
            rd_idx_r <= '0;
            if (reject) begin
              state_r <= ST_EMIT;
            end else begin
              wpos_r  <= wpos_nxt;
              fill_r  <= fill_nxt;
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // The ring read lands in rd_data_r and reaches the cells next cycle.
          // The read index stays on the last filled entry once the scan ends.
          feed_en_r <= 1'b1;
          if (scan_last) begin
            state_r <= ST_DRAIN;
          end else begin
            rd_idx_r <= rd_idx_r + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          state_r <= ST_MEDIAN;
        end
        ST_MEDIAN: begin
          med_r   <= med_c;
          state_r <= ST_MULT;
        end
        ST_MULT: begin
          if (!primed_r) begin
            smooth_r <= {med_r, {FRAC_W{1'b0}}};
            primed_r <= 1'b1;
            state_r  <= ST_EMIT;
          end else begin
            prod_r  <= prod_c;
            state_r <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          smooth_r <= acc_c[SMOOTH_W-1:0];
          state_r  <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_angle_r <= held_c;
            out_upd_r   <= upd_r;
            out_has_r   <= primed_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // An advanced filter always has a value to show.
  `AMF_ASSERT_IMPLIES(a_upd_has_value, out_tvalid && out_tuser[0], out_tuser[1], "updated without value")
  // Nothing held means a zero angle.
  `AMF_ASSERT_IMPLIES(a_empty_zero, out_tvalid && !out_tuser[1], out_tdata[13:0] == 14'd0, "nonzero angle without value")
  // The smoothed angle never leaves 0..180 degrees.
  `AMF_ASSERT_IMPLIES(a_angle_range, out_tvalid, out_tdata[13:0] <= ANGLE_MAX, "filtered angle above range")
  // The ring never counts more entries than it has, and the sequencer is busy after a transfer.
  `AMF_ASSERT_NEXT(a_busy_after_in, in_tvalid && in_tready, !in_tready && (fill_r <= CNT_W'(WINDOW)), "sequencer state after transfer")

endmodule

// ===== rtl/core/amf_sort_cell.sv =====
// One cell of the insertion sorter: holds one angle and a valid flag.
// Depends on amf_pkg.
`timescale 1ns / 1ps
module amf_sort_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clear,
  input  logic                          feed_en,
  input  logic [amf_pkg::ANGLE_W-1:0]   feed_val,
  input  amf_pkg::sort_link_t           left_i,
  output amf_pkg::sort_link_t           link_o
);
  import amf_pkg::*;

  logic [ANGLE_W-1:0] val_r, val_nxt;
  logic               valid_r, valid_nxt;
  logic               gt;

  // An empty cell counts as larger than any angle.
  assign gt     = !valid_r || (val_r > feed_val);
  assign link_o = '{val: val_r, valid: valid_r, gt: gt};

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (clear) begin
      valid_nxt = 1'b0;
    end else if (feed_en && gt) begin
      if (left_i.gt) begin
        val_nxt   = left_i.val;
        valid_nxt = left_i.valid;
      end else begin
        val_nxt   = feed_val;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== rtl/core/amf_sort_chain.sv =====
// Row of sort cells that orders the window ascending, one angle per cycle,
// and picks the two middle entries. Depends on amf_pkg and amf_sort_cell.
`timescale 1ns / 1ps
module amf_sort_chain #(
  parameter int WINDOW = 5,
  parameter int IDX_W  = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  logic                        feed_en,
  input  logic [amf_pkg::ANGLE_W-1:0] feed_val,
  input  logic [IDX_W-1:0]            half_idx,
  output logic [amf_pkg::ANGLE_W-1:0] mid_hi,
  output logic [amf_pkg::ANGLE_W-1:0] mid_lo
);
  import amf_pkg::*;

  sort_link_t links [WINDOW+1];

  // The head of the row never shifts anything in.
  assign links[0] = '{val: '0, valid: 1'b0, gt: 1'b0};

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    amf_sort_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clear    (clear),
      .feed_en  (feed_en),
      .feed_val (feed_val),
      .left_i   (links[g]),
      .link_o   (links[g+1])
    );
  end

  always_comb begin
    mid_hi = '0;
    mid_lo = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (i == int'(half_idx)) begin
        mid_hi = mid_hi | links[i+1].val;
      end
      if ((i + 1) == int'(half_idx)) begin
        mid_lo = mid_lo | links[i+1].val;
      end
    end
  end

endmodule

// ===== sim/angle_median_ema_filter_tb.sv =====
// Self-checking testbench for the angle median/EMA filter core.
// Depends on amf_pkg and the angle_median_ema_filter top level; needs no files.
`timescale 1ns / 1ps
module angle_median_ema_filter_tb;
  import amf_pkg::*;

  localparam int WINDOW = 5;
  localparam int PHASES = 11;

  // One expected output transfer: filtered_angle, updated and has_value.
  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               updated;
    logic               has_value;
  } filter_out_t;

  // Scoreboard: keeps its own copy of the filter state, predicts the output of
  // every accepted input transfer and compares output transfers in order.
  class angle_filter_scoreboard;
    logic [ANGLE_W-1:0] ring [WINDOW];
    int unsigned        slot;
    int unsigned        filled;
    int unsigned        zero_streak;
    logic [SMOOTH_W-1:0] ema;
    bit                 primed;
    logic [ALPHA_W-1:0] alpha;
    logic [ANGLE_W-1:0] zero_limit;
    logic [CONF_W-1:0]  confirm_need;
    filter_out_t        awaited_outputs[$];
    int                 errors;

    function new();
      slot = 0;
      filled = 0;
      zero_streak = 0;
      ema = '0;
      primed = 0;
      alpha = ALPHA_RST;
      zero_limit = THRESHOLD_RST;
      confirm_need = CONFIRM_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_EMA_ALPHA:      alpha = val[ALPHA_W-1:0];
        REG_ZERO_THRESHOLD: zero_limit = val[ANGLE_W-1:0];
        REG_ZERO_CONFIRM:   confirm_need = val[CONF_W-1:0];
        default: ;
      endcase
    endfunction

    // Rounded output of the average, or zero before anything was accepted.
    function logic [ANGLE_W-1:0] held();
      if (!primed) return '0;
      return ANGLE_W'((32'(ema) + 32'd128) >> 8);
    endfunction

    function filter_out_t smooth_frame(logic [RAW_W-1:0] raw);
      int unsigned angle;
      int unsigned med;
      int unsigned v;
      int unsigned p;
      int unsigned sorted [WINDOW];
      int          i;
      longint      weight;
      longint      delta;
      filter_out_t res;
      if (raw[RAW_W-1]) angle = 0;
      else if (raw > ANGLE_MAX) angle = ANGLE_MAX;
      else angle = raw;

      // Zero-looking frames are held back until enough of them came in a row.
      if (angle <= zero_limit) begin
        if (zero_streak < confirm_need) zero_streak++;
        if (zero_streak < confirm_need) begin
          res.angle = held();
          res.updated = 1'b0;
          res.has_value = primed;
          return res;
        end
      end else begin
        zero_streak = 0;
      end

      ring[slot] = ANGLE_W'(angle);
      slot = (slot + 1) % WINDOW;
      if (filled < WINDOW) filled++;

      for (i = 0; i < filled; i++) begin
        v = ring[i];
        p = i;
        while (p > 0 && v < sorted[p-1]) begin
          sorted[p] = sorted[p-1];
          p--;
        end
        sorted[p] = v;
      end
      if (filled % 2 == 0) med = (sorted[filled/2-1] + sorted[filled/2]) >> 1;
      else med = sorted[filled/2];

      if (!primed) begin
        ema = SMOOTH_W'(med << FRAC_W);
        primed = 1;
      end else begin
        weight = (alpha > ALPHA_MAX) ? ALPHA_MAX : alpha;
        delta = longint'(med) * 256 - longint'(ema);
        // Arithmetic shift gives the floor of the scaled step.
        ema = SMOOTH_W'(longint'(ema) + ((weight * delta) >>> 8));
      end
      res.angle = held();
      res.updated = 1'b1;
      res.has_value = 1'b1;
      return res;
    endfunction

    function void note_frame(logic [RAW_W-1:0] raw);
      awaited_outputs.push_back(smooth_frame(raw));
    endfunction

    function void report(string what, int want, int got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_result(logic [15:0] tdata, logic [1:0] tuser);
      filter_out_t want;
      if (awaited_outputs.size() == 0) begin
        report("unexpected output transfer, filtered_angle", -1, tdata[ANGLE_W-1:0]);
        return;
      end
      want = awaited_outputs.pop_front();
      if (tdata[ANGLE_W-1:0] !== want.angle) report("filtered_angle", want.angle, tdata[ANGLE_W-1:0]);
      if (tdata[15:ANGLE_W] !== '0) report("tdata padding", 0, tdata[15:ANGLE_W]);
      if (tuser[0] !== want.updated) report("updated", want.updated, tuser[0]);
      if (tuser[1] !== want.has_value) report("has_value", want.has_value, tuser[1]);
    endfunction

    function int outstanding();
      return awaited_outputs.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  angle_filter_scoreboard board = new();
  logic [15:0] frame_plan[$];
  int          frames_sent = 0;
  int          feed_gap_pct = 20;
  int          sink_stall_pct = 20;
  int          track_angle = 4000;
  bit          calm = 0;

  angle_median_ema_filter #(.WINDOW(WINDOW)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run, far above the slowest legal run with every stall.
  initial begin
    #3_000_000;
    $display("angle_median_ema_filter regression: fail");
    $finish;
  end

  // Every output transfer is checked at the rising edge where it happens.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_result(out_tdata, out_tuser);
    end
  end

  // Result sink. It stalls in short random bursts, and once, early in the run,
  // holds ready low for a long stretch while input transfers keep being
  // offered, so that the output register and the pipeline fill and the block
  // has to push back on its input.
  initial begin : result_sink
    bit squeezed;
    squeezed = 0;
    forever begin
      @(negedge clk);
      if (!squeezed && frames_sent >= 300) begin
        squeezed = 1;
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        out_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < sink_stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Writes one register; called at a falling edge and returns at one. The
  // valid is left high so back-to-back writes never toggle it within a step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic program_filter(input int alpha, input int thr, input int conf);
    write_reg(REG_EMA_ALPHA, CFG_DATA_W'(alpha));
    write_reg(REG_ZERO_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_ZERO_CONFIRM, CFG_DATA_W'(conf));
    cfg_valid <= 1'b0;
  endtask

  // Offers every planned angle in turn, with random gaps between transfers.
  task automatic play_frames();
    logic [15:0] raw;
    while (frame_plan.size() != 0) begin
      raw = frame_plan.pop_front();
      in_tdata <= raw;
      in_tvalid <= 1'b1;
      do @(posedge clk); while (!in_tready);
      board.note_frame(raw);
      frames_sent++;
      @(negedge clk);
      if (!calm && $urandom_range(0, 99) < feed_gap_pct) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
    end
    in_tvalid <= 1'b0;
  endtask

  // Every input transfer gives exactly one output, so the block is idle once
  // no output is owed any more.
  task automatic wait_drained();
    while (board.outstanding() != 0) @(negedge clk);
  endtask

  // Plans one phase: mostly a slowly wandering angle with small jitter, mixed
  // with runs of zero-looking frames, some long enough to pass the confirm count,
  // range extremes and fully random words. The plan is cut to its length.
  task automatic build_plan(input int count, input int thr, input int conf);
    int pick;
    int lim;
    int lo;
    int run;
    int k;
    int v;
    lim = (thr > ANGLE_MAX) ? ANGLE_MAX : thr;
    lo = (thr >= ANGLE_MAX) ? 0 : thr + 1;
    while (frame_plan.size() < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        track_angle = track_angle + int'($urandom_range(0, 600)) - 300;
        if (track_angle < lo) track_angle = lo;
        if (track_angle > ANGLE_MAX) track_angle = ANGLE_MAX;
        v = track_angle + int'($urandom_range(0, 40)) - 20;
        if (v < 0) v = 0;
        frame_plan.push_back(16'(v));
      end else if (pick < 75) begin
        run = $urandom_range(1, conf + 2);
        for (k = 0; k < run; k++) begin
          if ($urandom_range(0, 3) == 0) frame_plan.push_back(16'(16'h8000 | $urandom_range(0, 16'h7FFF)));
          else frame_plan.push_back(16'($urandom_range(0, lim)));
        end
      end else if (pick < 85) begin
        case ($urandom_range(0, 5))
          0: frame_plan.push_back(16'h8000);
          1: frame_plan.push_back(16'h7FFF);
          2: frame_plan.push_back(16'hFFFF);
          3: frame_plan.push_back(16'(ANGLE_MAX));
          4: frame_plan.push_back(16'(ANGLE_MAX + 1));
          default: frame_plan.push_back(16'(lim));
        endcase
      end else begin
        frame_plan.push_back(16'($urandom()));
      end
    end
    while (frame_plan.size() > count) void'(frame_plan.pop_back());
  endtask

  initial begin : stimulus
    int ph;
    int alpha;
    int thr;
    int conf;
    int len;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames at the reset settings: the most negative word and zero
    // are held back, the third zero-looking frame (exactly at the threshold)
    // is confirmed and loads the average, then the clamp limits, a negative
    // word inside a fresh zero run, and enough values to fill the window
    // through its even and odd counts.
    frame_plan = '{16'h8000, 16'h0000, 16'd32, 16'd33, 16'd11520, 16'd11521,
                   16'h7FFF, 16'h4000, 16'hFFFF, 16'd1, 16'd5000, 16'd3000,
                   16'd3001, 16'd9000, 16'd10, 16'd200};
    play_frames();
    wait_drained();

    // Weight above range acts as full weight, a threshold above range makes
    // every angle zero-looking, and a zero confirm count accepts them at once.
    program_filter(511, 16383, 0);
    frame_plan = '{16'h0000, 16'h8000, 16'd6000, 16'd11520};
    play_frames();
    wait_drained();

    for (ph = 0; ph < PHASES; ph++) begin
      len = 118;
      feed_gap_pct = (ph % 3 == 0) ? 0 : 30;
      sink_stall_pct = (ph % 4 == 1) ? 0 : 25;
      case (ph)
        0: begin
          alpha = 0; thr = 0; conf = 1;
        end
        1: begin
          // Everything is zero-looking; the long confirm count must be met.
          alpha = 256; thr = ANGLE_MAX; conf = 255; len = 260;
        end
        2: begin
          alpha = 128; thr = 500; conf = 2;
        end
        3: begin
          alpha = 511; thr = 16383; conf = 4;
        end
        PHASES - 1: begin
          // Back to the reset settings, with both sides running flat out.
          alpha = ALPHA_RST; thr = THRESHOLD_RST; conf = CONFIRM_RST;
          calm = 1;
        end
        default: begin
          alpha = $urandom_range(0, 511);
          thr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 2000);
          conf = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
        end
      endcase
      program_filter(alpha, thr, conf);
      build_plan(len, thr, conf);
      play_frames();
      wait_drained();
    end

    // Keep the clock running to catch any stray output transfer.
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("angle_median_ema_filter regression: pass");
    end else begin
      $display("angle_median_ema_filter regression: fail");
    end
    $finish;
  end

endmodule
